/* hdl/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;
    localparam int ID_W = 31;
    localparam int AGE_W = 8;
    localparam int NAME_W = 32;

    localparam logic [2:0] KIND_INSERT = 3'd0;
    localparam logic [2:0] KIND_POP = 3'd1;
    localparam logic [2:0] KIND_SEARCH = 3'd2;
    localparam logic [2:0] KIND_PEEK_FIRST = 3'd3;
    localparam logic [2:0] KIND_PEEK_LAST = 3'd4;
    localparam logic [2:0] KIND_LIST = 3'd5;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]        kind;
        logic [ID_W-1:0]   person_id;
        logic [AGE_W-1:0]  age_key;
        logic [NAME_W-1:0] name_handle;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   out_id;
        logic [AGE_W-1:0]  out_age;
        logic [NAME_W-1:0] out_name;
        logic [OCC_W-1:0]  occupancy;
        logic              last;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [AGE_W-1:0]  age;
        logic [NAME_W-1:0] name;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } cell_op_t;

endpackage

/* hdl/spq_cell.sv */
`timescale 1ns / 1ps

module spq_cell
(
    input  logic              clk,
    input  spq_pkg::cell_op_t op,
    input  spq_pkg::entry_t   new_ent,
    input  spq_pkg::entry_t   left_ent,
    input  logic              left_shift,
    input  spq_pkg::entry_t   right_ent,
    input  spq_pkg::entry_t   head_ent,
    input  logic              valid,
    input  logic              tail,
    output spq_pkg::entry_t   ent,
    output logic              shift,
    output logic              match
);

    spq_pkg::entry_t ent_reg;
    spq_pkg::entry_t ent_next;

    // A cell moves back on insert when it is empty or holds a strictly older key.
    assign shift = !valid || (ent_reg.age > new_ent.age);
    assign match = valid && (ent_reg.id == new_ent.id);
    assign ent = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        unique case (op)
            spq_pkg::CELL_HOLD:
            begin
                ent_next = ent_reg;
            end
            spq_pkg::CELL_INSERT:
            begin
                if (shift)
                begin
                    ent_next = left_shift ? left_ent : new_ent;
                end
            end
            spq_pkg::CELL_ROTATE:
            begin
                ent_next = tail ? head_ent : right_ent;
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

/* hdl/stable_sorted_priority_queue.sv */
`timescale 1ns / 1ps

// A sorted queue of up to DEPTH entries held in a row of cells, head first, ordered by
// ascending age with equal ages kept in arrival order. Insert, pop, search, peek first
// and peek last each give one result from the output register in the cycle after they
// are taken; a new request can follow as soon as that register is free. List all moves
// the whole row round as a ring, one entry per cycle from the head while the output
// register is free; requests are stalled during the run, and the row is back in its
// original order when the run ends. Unknown request kinds are taken and give no result.
module stable_sorted_priority_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output spq_pkg::rsp_t rsp
);

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [spq_pkg::CNT_W-1:0]   count_reg;
    logic [spq_pkg::CNT_W-1:0]   count_next;
    logic [spq_pkg::CNT_W-1:0]   remain_reg;
    logic [spq_pkg::CNT_W-1:0]   remain_next;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    spq_pkg::rsp_t               rsp_reg;
    spq_pkg::rsp_t               rsp_next;

    spq_pkg::cell_op_t           cell_op;
    spq_pkg::entry_t             new_ent;
    spq_pkg::entry_t             ent [spq_pkg::DEPTH];
    logic [spq_pkg::DEPTH-1:0]   shift;
    logic [spq_pkg::DEPTH-1:0]   match;
    logic [spq_pkg::DEPTH-1:0]   occ_mask;
    logic [spq_pkg::DEPTH-1:0]   tail;
    logic [spq_pkg::DEPTH-1:0]   hit;
    logic [spq_pkg::DEPTH-1:0]   first_hit;
    logic [spq_pkg::ENT_W-1:0]   found_vec;
    logic [spq_pkg::ENT_W-1:0]   last_vec;
    spq_pkg::entry_t             found_ent;
    spq_pkg::entry_t             last_ent;
    logic                        out_free;
    logic                        accept;
    logic                        empty;
    logic                        full;

    assign new_ent.id = req.person_id;
    assign new_ent.age = req.age_key;
    assign new_ent.name = req.name_handle;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg == ST_LIST) || !out_free;
    assign accept = req_valid && !req_stall;
    assign empty = (count_reg == '0);
    assign full = (count_reg == spq_pkg::CNT_W'(spq_pkg::DEPTH));

    genvar gi;
    generate
        for (gi = 0; gi < spq_pkg::DEPTH; gi++)
        begin : g_cell
            assign occ_mask[gi] = (spq_pkg::CNT_W'(gi) < count_reg);

            if (gi == spq_pkg::DEPTH - 1)
            begin : g_end
                assign tail[gi] = occ_mask[gi];
            end
            else
            begin : g_mid
                assign tail[gi] = occ_mask[gi] && !occ_mask[gi+1];
            end

            spq_cell u_cell
            (
                .clk        (clk),
                .op         (cell_op),
                .new_ent    (new_ent),
                .left_ent   (ent[(gi == 0) ? 0 : gi - 1]),
                .left_shift ((gi == 0) ? 1'b0 : shift[(gi == 0) ? 0 : gi - 1]),
                .right_ent  (ent[(gi == spq_pkg::DEPTH - 1) ? gi : gi + 1]),
                .head_ent   (ent[0]),
                .valid      (occ_mask[gi]),
                .tail       (tail[gi]),
                .ent        (ent[gi]),
                .shift      (shift[gi]),
                .match      (match[gi])
            );
        end
    endgenerate

    // The first match from the head is isolated as the lowest set bit.
    assign hit = match & occ_mask;
    assign first_hit = hit & (~hit + spq_pkg::DEPTH'(1));

    always_comb
    begin
        found_vec = '0;
        last_vec = '0;
        for (int i = 0; i < spq_pkg::DEPTH; i++)
        begin
            if (first_hit[i])
            begin
                found_vec = found_vec | ent[i];
            end
            if (tail[i])
            begin
                last_vec = last_vec | ent[i];
            end
        end
    end

    assign found_ent = spq_pkg::entry_t'(found_vec);
    assign last_ent = spq_pkg::entry_t'(last_vec);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        remain_next = remain_reg;
        rsp_valid_next = out_free ? 1'b0 : rsp_valid_reg;
        rsp_next = rsp_reg;
        cell_op = spq_pkg::CELL_HOLD;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_next = '0;
                    rsp_next.last = 1'b1;
                    rsp_valid_next = 1'b1;
                    priority case (req.kind)
                        spq_pkg::KIND_INSERT:
                        begin
                            if (full)
                            begin
                                rsp_next.status = spq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                cell_op = spq_pkg::CELL_INSERT;
                                count_next = count_reg + spq_pkg::CNT_W'(1);
                                rsp_next.status = spq_pkg::STATUS_OK;
                            end
                        end
                        spq_pkg::KIND_POP:
                        begin
                            if (empty)
                            begin
                                rsp_next.status = spq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                cell_op = spq_pkg::CELL_ROTATE;
                                count_next = count_reg - spq_pkg::CNT_W'(1);
                                rsp_next.status = spq_pkg::STATUS_OK;
                                rsp_next.out_id = ent[0].id;
                                rsp_next.out_age = ent[0].age;
                                rsp_next.out_name = ent[0].name;
                            end
                        end
                        spq_pkg::KIND_SEARCH:
                        begin
                            if (empty)
                            begin
                                rsp_next.status = spq_pkg::STATUS_EMPTY;
                            end
                            else if (hit == '0)
                            begin
                                rsp_next.status = spq_pkg::STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                rsp_next.status = spq_pkg::STATUS_OK;
                                rsp_next.out_id = found_ent.id;
                                rsp_next.out_age = found_ent.age;
                                rsp_next.out_name = found_ent.name;
                            end
                        end
                        spq_pkg::KIND_PEEK_FIRST:
                        begin
                            if (empty)
                            begin
                                rsp_next.status = spq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rsp_next.status = spq_pkg::STATUS_OK;
                                rsp_next.out_id = ent[0].id;
                                rsp_next.out_age = ent[0].age;
                                rsp_next.out_name = ent[0].name;
                            end
                        end
                        spq_pkg::KIND_PEEK_LAST:
                        begin
                            if (empty)
                            begin
                                rsp_next.status = spq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rsp_next.status = spq_pkg::STATUS_OK;
                                rsp_next.out_id = last_ent.id;
                                rsp_next.out_age = last_ent.age;
                                rsp_next.out_name = last_ent.name;
                            end
                        end
                        spq_pkg::KIND_LIST:
                        begin
                            if (empty)
                            begin
                                rsp_next.status = spq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                rsp_valid_next = 1'b0;
                                remain_next = count_reg;
                                state_next = ST_LIST;
                            end
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b0;
                        end
                    endcase
                    rsp_next.occupancy = spq_pkg::OCC_W'(count_next);
                end
            end
            ST_LIST:
            begin
                if (out_free)
                begin
                    cell_op = spq_pkg::CELL_ROTATE;
                    rsp_valid_next = 1'b1;
                    rsp_next.status = spq_pkg::STATUS_OK;
                    rsp_next.out_id = ent[0].id;
                    rsp_next.out_age = ent[0].age;
                    rsp_next.out_name = ent[0].name;
                    rsp_next.occupancy = spq_pkg::OCC_W'(count_reg);
                    rsp_next.last = (remain_reg == spq_pkg::CNT_W'(1));
                    remain_next = remain_reg - spq_pkg::CNT_W'(1);
                    if (remain_reg == spq_pkg::CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            remain_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            remain_reg <= remain_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
    else $error("Entry count exceeds the depth.");

    a_list_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIST) |=> (count_reg == $past(count_reg)))
    else $error("Entry count changed during a list run.");

    a_run_only_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && !rsp.last) |-> (state_reg == ST_LIST))
    else $error("A result not marked last appeared outside a list run.");

    a_full_insert_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.kind == spq_pkg::KIND_INSERT) && full) |=> $stable(count_reg))
    else $error("An insert into a full queue changed the entry count.");
`endif

endmodule
